>>> rtl/sidt_pkg.sv
package sidt_pkg;

  localparam int unsigned SLOT_COUNT = 16;
  localparam int unsigned IDX_W      = $clog2(SLOT_COUNT);
  localparam int unsigned SLOT_W     = 5;
  localparam int unsigned ID_W       = 32;

  localparam logic [ID_W-1:0] FREE_MARK = 32'hFFFF_FFFF;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  typedef enum logic [1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_EXISTS    = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_FULL      = 2'd3
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture request, restart scan
    logic step;    // issue read at scan address, advance
    logic commit;  // apply update, launch result
  } sidt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;  // scan address sits on the last slot
  } sidt_sts_t;

endpackage

>>> rtl/sidt_ctrl.sv
module sidt_ctrl
  import sidt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  sidt_sts_t sts_i,
  output sidt_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_COMMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      // last read still in the compare stage
      ST_DRAIN: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

>>> rtl/sidt_dpath.sv
module sidt_dpath
  import sidt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sidt_cmd_t         cmd_i,
  output sidt_sts_t         sts_o,
  input  logic [1:0]        command_i,
  input  logic [ID_W-1:0]   sess_key_i,
  output logic              done_o,
  output logic [SLOT_W-1:0] slot_index_o,
  output logic [1:0]        status_o,
  output logic [SLOT_W-1:0] live_count_o
);

  localparam logic [IDX_W-1:0]  LastAddr = IDX_W'(SLOT_COUNT - 1);
  localparam logic [SLOT_W-1:0] NoSlot   = SLOT_W'(SLOT_COUNT);

  logic [ID_W-1:0]       mem_q [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] valid_q;

  logic [1:0]        cmd_q;
  logic [ID_W-1:0]   key_q;
  logic [IDX_W-1:0]  addr_q;
  logic [ID_W-1:0]   rd_data_q;
  logic              rd_valid_q;
  logic [IDX_W-1:0]  cmp_idx_q;
  logic              cmp_vld_q;
  logic              hit_q, free_q;
  logic [IDX_W-1:0]  hit_idx_q, free_idx_q;
  logic [SLOT_W-1:0] count_q, count_d;
  logic              done_q;
  logic [SLOT_W-1:0] slot_q, slot_d;
  status_e           status_q, status_d;

  logic [ID_W-1:0] entry;
  logic            key_ok;
  logic            do_ins, do_rem;

  assign sts_o.scan_last = (addr_q == LastAddr);

  // slot not yet written, or freed, reads as the free marker
  assign entry  = rd_valid_q ? rd_data_q : FREE_MARK;
  assign key_ok = (key_q != FREE_MARK);

  // registered read port
  always_ff @(posedge clk_i) begin
    rd_data_q  <= mem_q[addr_q];
    rd_valid_q <= valid_q[addr_q];
    cmp_idx_q  <= addr_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= command_i;
      key_q <= sess_key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q     <= '0;
      cmp_vld_q  <= 1'b0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      hit_idx_q  <= '0;
      free_idx_q <= '0;
    end else begin
      cmp_vld_q <= cmd_i.step;
      if (cmd_i.load) begin
        addr_q <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else begin
        if (cmd_i.step) begin
          addr_q <= addr_q + 1'b1;
        end
        // keep the lowest match of each kind
        if (cmp_vld_q) begin
          if (!hit_q && key_ok && entry == key_q) begin
            hit_q     <= 1'b1;
            hit_idx_q <= cmp_idx_q;
          end
          if (!free_q && entry == FREE_MARK) begin
            free_q     <= 1'b1;
            free_idx_q <= cmp_idx_q;
          end
        end
      end
    end
  end

  always_comb begin
    do_ins   = 1'b0;
    do_rem   = 1'b0;
    count_d  = count_q;
    slot_d   = NoSlot;
    status_d = STATUS_NOT_FOUND;
    if (key_ok) begin
      case (cmd_q)
        CMD_INSERT: begin
          if (hit_q) begin
            slot_d   = SLOT_W'(hit_idx_q);
            status_d = STATUS_EXISTS;
          end else if (free_q) begin
            do_ins   = 1'b1;
            count_d  = count_q + 1'b1;
            slot_d   = SLOT_W'(free_idx_q);
            status_d = STATUS_DONE;
          end else begin
            status_d = STATUS_FULL;
          end
        end
        CMD_REMOVE: begin
          if (hit_q) begin
            do_rem   = 1'b1;
            if (count_q != '0) begin
              count_d = count_q - 1'b1;
            end
            slot_d   = SLOT_W'(hit_idx_q);
            status_d = STATUS_DONE;
          end
        end
        default: begin
          if (hit_q) begin
            slot_d   = SLOT_W'(hit_idx_q);
            status_d = STATUS_DONE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && do_ins) begin
      mem_q[free_idx_q] <= key_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= cmd_i.commit;
      if (cmd_i.commit) begin
        count_q <= count_d;
        if (do_ins) begin
          valid_q[free_idx_q] <= 1'b1;
        end
        if (do_rem) begin
          valid_q[hit_idx_q] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      slot_q   <= slot_d;
      status_q <= status_d;
    end
  end

  assign done_o       = done_q;
  assign slot_index_o = slot_q;
  assign status_o     = status_q;
  assign live_count_o = count_q;

endmodule

>>> rtl/session_id_table_unit.sv
// Session ID table: 16 slots of 32-bit IDs with a live count. A request beat
// (command, sess_key) is taken when start is high and busy is low; its one
// result shows on done_o for a single cycle and cannot be stalled, so the
// receiver must take it then. Each request walks the slot memory one entry a
// cycle through a registered read port, finding the first match and the first
// free slot in the same pass: busy stays high through the scan, drain and
// commit states after accept, and done_o pulses in the cycle busy falls.
// A new request may be started in that same cycle. Slots come out of reset
// free (per-slot valid bits), so no clearing pass is needed.
module session_id_table_unit
  import sidt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        command_i,
  input  logic [ID_W-1:0]   sess_key_i,
  output logic              done_o,
  output logic [SLOT_W-1:0] slot_index_o,
  output logic [1:0]        status_o,
  output logic [SLOT_W-1:0] live_count_o
);

  sidt_cmd_t cmd;
  sidt_sts_t sts;

  sidt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  sidt_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .command_i    (command_i),
    .sess_key_i   (sess_key_i),
    .done_o       (done_o),
    .slot_index_o (slot_index_o),
    .status_o     (status_o),
    .live_count_o (live_count_o)
  );

endmodule

>>> rtl/sidt_checker.sv
module sidt_checker
  import sidt_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              done_o,
  input logic [SLOT_W-1:0] slot_index_o,
  input logic [1:0]        status_o,
  input logic [SLOT_W-1:0] live_count_o
);

  localparam logic [SLOT_W-1:0] NoSlot = SLOT_W'(SLOT_COUNT);

  // accepted request keeps the unit busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accepted request");

  // a result beat only ever follows a busy period
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy && $past(busy))
    else $error("result beat without a preceding request");

  a_miss_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == STATUS_NOT_FOUND || status_o == STATUS_FULL)
      |-> slot_index_o == NoSlot)
    else $error("miss or full result carries a slot index");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == STATUS_FULL |-> live_count_o == NoSlot)
    else $error("table full reported below capacity");

  a_hit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == STATUS_DONE || status_o == STATUS_EXISTS)
      |-> slot_index_o < NoSlot && live_count_o <= NoSlot)
    else $error("hit result out of range");

endmodule

bind session_id_table_unit sidt_checker u_sidt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .slot_index_o (slot_index_o),
  .status_o     (status_o),
  .live_count_o (live_count_o)
);
